// ----- hdl/wacs_pkg.sv -----
package wacs_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OPEN_THRESHOLD    = 3'd0,
    REG_SERVO_OPEN_WIDTH  = 3'd1,
    REG_SERVO_CLOSE_WIDTH = 3'd2,
    REG_SERVO_PERIOD      = 3'd3,
    REG_SERVO_HOLD_TICKS  = 3'd4,
    REG_PHASE_HOLD_TICKS  = 3'd5,
    REG_STEP_CYCLES       = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE        = 3'd0,
    S_OPEN_SERVO  = 3'd1,
    S_OPEN_STEP   = 3'd2,
    S_CLOSE_STEP  = 3'd3,
    S_CLOSE_SERVO = 3'd4
  } seq_state_t;

  localparam logic [11:0] OPEN_THRESHOLD_RST    = 12'd256;
  localparam logic [5:0]  SERVO_OPEN_WIDTH_RST  = 6'd3;
  localparam logic [5:0]  SERVO_CLOSE_WIDTH_RST = 6'd1;
  localparam logic [5:0]  SERVO_PERIOD_RST      = 6'd40;
  localparam logic [23:0] SERVO_HOLD_TICKS_RST  = 24'd500;
  localparam logic [15:0] PHASE_HOLD_TICKS_RST  = 16'd2;
  localparam logic [9:0]  STEP_CYCLES_RST       = 10'd250;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // opening drives coils 3,2,1,0, closing drives 0,1,2,3
  function automatic logic [3:0] coil_onehot(input logic [1:0] idx, input logic opening);
    logic [1:0] sel;
    sel = opening ? ~idx : idx;
    return 4'b0001 << sel;
  endfunction

endpackage

// ----- hdl/wacs_item_if.sv -----
interface wacs_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] sample;

  modport source (output valid, command, sample, input ready);
  modport sink (input valid, command, sample, output ready);
endinterface

// ----- hdl/wacs_result_if.sv -----
interface wacs_result_if;
  logic       valid;
  logic       ready;
  logic       servo_pin;
  logic       indicator_pin;
  logic [3:0] coils;
  logic       busy_res;
  logic       is_closed;

  modport source (output valid, servo_pin, indicator_pin, coils, busy_res, is_closed,
                  input ready);
  modport sink (input valid, servo_pin, indicator_pin, coils, busy_res, is_closed,
                output ready);
endinterface

// ----- hdl/wacs_cfg_if.sv -----
interface wacs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wacs_pkg::CFG_INDEX_W-1:0] index;
  logic [wacs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/window_actuator_sequencer.sv -----
// window actuator sequencer: servo latch plus stepper drive for a window
//
// channels
//   items   : tick (command 0) or sensor sample (command 1, sample 12 bits)
//   results : servo_pin, indicator_pin, coils, busy_res, is_closed; exactly
//             one result transaction per item transaction
//   cfg     : register writes, index 0..6, data in the low bits; ready is
//             always high, unknown indexes are dropped
// timing
//   an item is applied in the cycle it is taken and its result sits in the
//   output register from the next cycle on; one item per cycle sustained while
//   results are taken, set by the single output register: items.ready is high
//   while that register is empty or being emptied in the same cycle
// stall
//   a stalled result holds the output register and items.ready drops until
//   the result transaction completes; no item is lost or duplicated
// reset (rst, synchronous)
//   registers return to their defaults, window reads open, sequencer idle,
//   coils off, servo and indicator low, no result pending
module window_actuator_sequencer (
  input logic clk,
  input logic rst,
  wacs_item_if.sink     items,
  wacs_result_if.source results,
  wacs_cfg_if.sink      cfg
);
  import wacs_pkg::*;

  // configuration registers
  logic [11:0] open_threshold;
  logic [5:0]  servo_open_width;
  logic [5:0]  servo_close_width;
  logic [5:0]  servo_period;
  logic [23:0] servo_hold_ticks;
  logic [15:0] phase_hold_ticks;
  logic [9:0]  step_cycles;

  // sequencer state
  seq_state_t  state, state_next;
  logic        closed_flag, closed_flag_next;
  logic [5:0]  pulse_width, pulse_width_next;
  logic [5:0]  pwm_count, pwm_count_next;
  logic [23:0] hold_timer, hold_timer_next;
  logic [9:0]  cycle_count, cycle_count_next;
  logic [1:0]  coil_index, coil_index_next;
  logic [3:0]  coil_drive, coil_drive_next;
  logic        servo_level, servo_level_next;
  logic        indicator_level, indicator_level_next;

  // output register
  logic out_valid;

  // handshake and decode
  logic item_fire;
  logic is_tick;
  logic is_idle;
  logic above;
  logic open_req;
  logic close_req;

  // shared step terms
  logic        hold_done;
  logic [1:0]  idx_inc;
  logic        idx_wrap;
  logic [9:0]  cyc_inc;
  logic        steps_done;
  logic        no_steps;
  logic [5:0]  pwm_inc;

  assign cfg.ready       = 1'b1;
  assign items.ready     = !out_valid || results.ready;
  assign item_fire       = items.valid && items.ready;
  assign is_tick         = items.command == CMD_TICK;
  assign is_idle         = state == S_IDLE;
  assign above           = items.sample > open_threshold;
  // samples only act while idle and only when they ask for a move
  assign open_req        = !is_tick && is_idle && above && closed_flag;
  assign close_req       = !is_tick && is_idle && !above && !closed_flag;

  // zero hold counts behave as one tick
  assign hold_done  = hold_timer <= 24'd1;
  assign idx_inc    = coil_index + 2'd1;
  assign idx_wrap   = idx_inc == 2'd0;
  assign cyc_inc    = cycle_count + 10'd1;
  assign steps_done = idx_wrap && (cyc_inc >= step_cycles);
  assign no_steps   = step_cycles == 10'd0;
  assign pwm_inc    = pwm_count + 6'd1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      open_threshold    <= OPEN_THRESHOLD_RST;
      servo_open_width  <= SERVO_OPEN_WIDTH_RST;
      servo_close_width <= SERVO_CLOSE_WIDTH_RST;
      servo_period      <= SERVO_PERIOD_RST;
      servo_hold_ticks  <= SERVO_HOLD_TICKS_RST;
      phase_hold_ticks  <= PHASE_HOLD_TICKS_RST;
      step_cycles       <= STEP_CYCLES_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_OPEN_THRESHOLD:    open_threshold    <= cfg.data[11:0];
        REG_SERVO_OPEN_WIDTH:  servo_open_width  <= cfg.data[5:0];
        REG_SERVO_CLOSE_WIDTH: servo_close_width <= cfg.data[5:0];
        REG_SERVO_PERIOD:      servo_period      <= cfg.data[5:0];
        REG_SERVO_HOLD_TICKS:  servo_hold_ticks  <= cfg.data[23:0];
        REG_PHASE_HOLD_TICKS:  phase_hold_ticks  <= cfg.data[15:0];
        REG_STEP_CYCLES:       step_cycles       <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  // next state of the move sequencer
  always_comb begin
    state_next = state;
    if (item_fire) begin
      if (is_tick) begin
        unique case (state)
          S_IDLE: state_next = S_IDLE;
          S_OPEN_SERVO: begin
            if (hold_done) state_next = no_steps ? S_IDLE : S_OPEN_STEP;
          end
          S_OPEN_STEP: begin
            if (hold_done && steps_done) state_next = S_IDLE;
          end
          S_CLOSE_STEP: begin
            if (hold_done && steps_done) state_next = S_CLOSE_SERVO;
          end
          S_CLOSE_SERVO: begin
            if (hold_done) state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end else if (open_req) begin
        state_next = S_OPEN_SERVO;
      end else if (close_req) begin
        // closing with no stepper cycles goes straight to the latch
        state_next = no_steps ? S_CLOSE_SERVO : S_CLOSE_STEP;
      end
    end
  end

  // datapath updates driven by the sequencer
  always_comb begin
    closed_flag_next     = closed_flag;
    pulse_width_next     = pulse_width;
    pwm_count_next       = pwm_count;
    hold_timer_next      = hold_timer;
    cycle_count_next     = cycle_count;
    coil_index_next      = coil_index;
    coil_drive_next      = coil_drive;
    servo_level_next     = servo_level;
    indicator_level_next = indicator_level;
    if (item_fire) begin
      if (is_tick) begin
        // servo pwm runs on every tick, using the width before this tick's move
        indicator_level_next = pulse_width != 6'd0;
        servo_level_next     = pwm_inc <= pulse_width;
        pwm_count_next       = (pwm_inc >= servo_period) ? 6'd0 : pwm_inc;
        unique case (state)
          S_IDLE: ;
          S_OPEN_SERVO: begin
            if (!hold_done) begin
              hold_timer_next = hold_timer - 24'd1;
            end else begin
              pulse_width_next = 6'd0;
              cycle_count_next = 10'd0;
              coil_index_next  = 2'd0;
              if (no_steps) begin
                closed_flag_next = 1'b0;
              end else begin
                coil_drive_next = coil_onehot(2'd0, 1'b1);
                hold_timer_next = {8'd0, phase_hold_ticks};
              end
            end
          end
          S_OPEN_STEP, S_CLOSE_STEP: begin
            if (!hold_done) begin
              hold_timer_next = hold_timer - 24'd1;
            end else begin
              coil_index_next = idx_inc;
              if (idx_wrap) cycle_count_next = cyc_inc;
              if (!steps_done) begin
                coil_drive_next = coil_onehot(idx_inc, state == S_OPEN_STEP);
                hold_timer_next = {8'd0, phase_hold_ticks};
              end else if (state == S_OPEN_STEP) begin
                closed_flag_next = 1'b0;
              end else begin
                // stepping done while closing: engage the latch
                pulse_width_next = servo_close_width;
                hold_timer_next  = servo_hold_ticks;
              end
            end
          end
          S_CLOSE_SERVO: begin
            if (!hold_done) begin
              hold_timer_next = hold_timer - 24'd1;
            end else begin
              pulse_width_next = 6'd0;
              closed_flag_next = 1'b1;
            end
          end
          default: ;
        endcase
      end else if (open_req) begin
        pulse_width_next = servo_open_width;
        hold_timer_next  = servo_hold_ticks;
      end else if (close_req) begin
        cycle_count_next = 10'd0;
        coil_index_next  = 2'd0;
        if (no_steps) begin
          pulse_width_next = servo_close_width;
          hold_timer_next  = servo_hold_ticks;
        end else begin
          coil_drive_next = coil_onehot(2'd0, 1'b0);
          hold_timer_next = {8'd0, phase_hold_ticks};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      closed_flag     <= 1'b0;
      pulse_width     <= 6'd0;
      pwm_count       <= 6'd0;
      hold_timer      <= 24'd0;
      cycle_count     <= 10'd0;
      coil_index      <= 2'd0;
      coil_drive      <= 4'd0;
      servo_level     <= 1'b0;
      indicator_level <= 1'b0;
    end else begin
      state           <= state_next;
      closed_flag     <= closed_flag_next;
      pulse_width     <= pulse_width_next;
      pwm_count       <= pwm_count_next;
      hold_timer      <= hold_timer_next;
      cycle_count     <= cycle_count_next;
      coil_index      <= coil_index_next;
      coil_drive      <= coil_drive_next;
      servo_level     <= servo_level_next;
      indicator_level <= indicator_level_next;
    end
  end

  // result register: loaded with the post-item state on every item transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      results.servo_pin     <= servo_level_next;
      results.indicator_pin <= indicator_level_next;
      results.coils         <= coil_drive_next;
      results.busy_res      <= state_next != S_IDLE;
      results.is_closed     <= closed_flag_next;
    end
  end

  assign results.valid = out_valid;

`ifndef SYNTH
  // an accepted open request always starts the unlatch phase
  a_open_starts: assert property (@(posedge clk) disable iff (rst)
    item_fire && open_req |=> state == S_OPEN_SERVO)
    else $error("open request did not start the servo unlatch");

  // samples taken while a move runs leave the sequencer alone
  a_busy_sample_ignored: assert property (@(posedge clk) disable iff (rst)
    item_fire && !is_tick && !is_idle |=> state == $past(state) &&
      hold_timer == $past(hold_timer))
    else $error("sample disturbed a running move");

  // exactly one coil is driven while stepping
  a_one_coil: assert property (@(posedge clk) disable iff (rst)
    (state == S_OPEN_STEP || state == S_CLOSE_STEP) |-> $onehot(coil_drive))
    else $error("coil drive not one-hot while stepping");

  // a pending result is never overwritten without being taken
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !results.ready |-> !item_fire)
    else $error("item accepted over a stalled result");
`endif

endmodule
